@@ rtl/core/neighbor_table_aging_engine_defines.svh @@
// ---------------------------------------------------------------------------
// Neighbor table aging engine assertion macros
// Shared helpers for writing clocked assertions in the RTL.
// ---------------------------------------------------------------------------
`ifndef NEIGHBOR_TABLE_AGING_ENGINE_DEFINES_SVH
`define NEIGHBOR_TABLE_AGING_ENGINE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define NTE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("neighbor table check failed");

// Next-cycle implication, checked on every rising edge out of reset.
`define NTE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("neighbor table check failed");

`endif

@@ rtl/core/nte_pkg.sv @@
// ---------------------------------------------------------------------------
// Neighbor table aging engine package
// Types, codes and small lookup functions shared by the engine modules.
// ---------------------------------------------------------------------------
package nte_pkg;

    typedef enum logic [1:0] {
        CMD_BEACON = 2'd0,
        CMD_TICK   = 2'd1,
        CMD_MODE   = 2'd2,
        CMD_FIND   = 2'd3
    } cmd_code_t;

    localparam logic [1:0] KIND_BEACON    = 2'd0;
    localparam logic [1:0] KIND_LINK_DOWN = 2'd1;
    localparam logic [1:0] KIND_FIND      = 2'd2;

    localparam logic [1:0] MODE_DEEP_SLEEP = 2'd0;
    localparam logic [1:0] MODE_WATCH      = 2'd1;
    localparam logic [1:0] MODE_ALERT      = 2'd2;
    localparam logic [1:0] MODE_REALTIME   = 2'd3;

    localparam logic [1:0] REG_OWN_ID       = 2'd0;
    localparam logic [1:0] REG_OWN_HOP      = 2'd1;
    localparam logic [1:0] REG_OWN_TX_POWER = 2'd2;

    localparam logic [7:0] OWN_HOP_RESET  = 8'hFF;
    localparam logic [7:0] BEACON_CAP     = 8'h01;
    localparam logic [7:0] HISTORY_NEW    = 8'h01;
    localparam logic [6:0] QUALITY_NEW    = 7'd12;

    // Interval and timeout values fit in 21 bits.
    localparam int TIME_W = 21;

    typedef struct packed {
        logic [15:0] node;
        logic [7:0]  rssi;
        logic [6:0]  quality;
        logic [31:0] seen;
        logic [7:0]  hop;
        logic [7:0]  power;
        logic [7:0]  capability;
        logic [7:0]  history;
        logic [3:0]  decay;
    } entry_t;

    typedef struct packed {
        logic load;
        logic decode;
        logic scan_step;
        logic commit;
        logic emit_find;
        logic emit_bcn;
        logic emit_down;
    } ctl_t;

    typedef struct packed {
        cmd_code_t cmd;
        logic      drop;
        logic      mode_zero;
        logic      shrink;
        logic      scan_end;
        logic      bcn_due;
        logic      any_down;
        logic      last_down;
    } stat_t;

    function automatic logic [TIME_W-1:0] interval_of(input logic [1:0] m);
        logic [TIME_W-1:0] v;
        case (m)
            MODE_REALTIME: v = 21'd1000;
            MODE_ALERT:    v = 21'd5000;
            MODE_WATCH:    v = 21'd30000;
            default:       v = 21'd300000;
        endcase
        return v;
    endfunction

    function automatic logic [TIME_W-1:0] timeout_of(input logic [1:0] m);
        logic [TIME_W-1:0] v;
        case (m)
            MODE_REALTIME: v = 21'd3000;
            MODE_ALERT:    v = 21'd15000;
            MODE_WATCH:    v = 21'd120000;
            default:       v = 21'd1200000;
        endcase
        return v;
    endfunction

    // Percentage of ones in the eight-beacon reception history.
    function automatic logic [6:0] quality_of(input logic [7:0] h);
        logic [3:0] n;
        logic [6:0] q;
        n = 4'd0;
        for (int i = 0; i < 8; i++) begin
            n = n + {3'd0, h[i]};
        end
        case (n)
            4'd0:    q = 7'd0;
            4'd1:    q = 7'd12;
            4'd2:    q = 7'd25;
            4'd3:    q = 7'd37;
            4'd4:    q = 7'd50;
            4'd5:    q = 7'd62;
            4'd6:    q = 7'd75;
            4'd7:    q = 7'd87;
            default: q = 7'd100;
        endcase
        return q;
    endfunction

endpackage

@@ rtl/core/nte_datapath.sv @@
// ---------------------------------------------------------------------------
// Neighbor table datapath
// Table memory, valid bits, scan pipeline, counters and result register.
// ---------------------------------------------------------------------------
module nte_datapath #(
    parameter int TABLE_ENTRIES        = 32,
    parameter int MAX_EXPIRED_PER_TICK = 4,
    parameter int DECAY_LIMIT          = 8,
    parameter int BEACON_BYTES         = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  nte_pkg::ctl_t       ctl,
    output nte_pkg::stat_t      stat,
    input  logic [15:0]         own_id,
    input  logic [7:0]          own_hop,
    input  logic [7:0]          own_tx_power,
    input  logic [1:0]          command,
    input  logic [31:0]         now_ms,
    input  logic [15:0]         source_id,
    input  logic [7:0]          packet_length,
    input  logic [7:0]          source_hop,
    input  logic signed [7:0]   source_power,
    input  logic [7:0]          source_capability,
    input  logic [7:0]          received_rssi,
    input  logic [1:0]          new_mode,
    input  logic [15:0]         query_id,
    output logic                result_strobe,
    output logic [1:0]          item_kind,
    output logic [15:0]         node_id,
    output logic [7:0]          hop_count,
    output logic signed [7:0]   tx_power,
    output logic [7:0]          capability,
    output logic [7:0]          signal_strength,
    output logic [6:0]          link_quality,
    output logic [31:0]         seen_time_ms,
    output logic [5:0]          neighbor_total,
    output logic [7:0]          beacon_sequence,
    output logic                found,
    output logic                last_item
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int PTR_W = IDX_W + 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int NG_W  = $clog2(MAX_EXPIRED_PER_TICK + 1);
    localparam int GI_W  = (MAX_EXPIRED_PER_TICK > 1) ? $clog2(MAX_EXPIRED_PER_TICK) : 1;
    localparam int TW    = nte_pkg::TIME_W;

    // Latched command fields.
    nte_pkg::cmd_code_t cmd_reg;
    logic [31:0] now_reg;
    logic [15:0] src_reg;
    logic [7:0]  len_reg;
    logic [7:0]  shop_reg;
    logic [7:0]  spow_reg;
    logic [7:0]  scap_reg;
    logic [7:0]  rssi_reg;
    logic [1:0]  nmode_reg;
    logic [15:0] qid_reg;

    // Engine state.
    logic [1:0]               mode_reg;
    logic                     pending_reg;
    logic [7:0]               bcnt_reg;
    logic [CNT_W-1:0]         vcount_reg;
    logic [31:0]              lbt_reg;
    logic [TABLE_ENTRIES-1:0] valid_reg;

    nte_pkg::entry_t mem [TABLE_ENTRIES];
    nte_pkg::entry_t rd_data_reg;

    logic [PTR_W-1:0] rd_ptr_reg;
    logic             p_vld_reg;
    logic [IDX_W-1:0] p_idx_reg;

    logic             match_reg;
    logic [IDX_W-1:0] match_idx_reg;
    nte_pkg::entry_t  match_ent_reg;
    logic             free_reg;
    logic [IDX_W-1:0] free_idx_reg;

    logic [NG_W-1:0]  ng_reg;
    logic [NG_W-1:0]  down_ptr_reg;
    logic [15:0]      gone_reg [MAX_EXPIRED_PER_TICK];

    logic [TW-1:0]    ivl;
    logic [TW-1:0]    tmo;
    nte_pkg::entry_t  p_ent;
    logic             p_valid;
    logic [31:0]      age;
    logic [4:0]       dc1;
    logic [25:0]      thr;
    logic             is_exp;
    logic             stop;
    logic             do_decay;
    logic [15:0]      key;
    logic             hit;
    logic             proc;
    logic             rd_go;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    nte_pkg::entry_t  wr_data;
    logic [CNT_W+5:0] vcount_ext;

    always_comb
    begin
        ivl     = nte_pkg::interval_of(mode_reg);
        tmo     = nte_pkg::timeout_of(mode_reg);
        p_ent   = rd_data_reg;
        p_valid = valid_reg[p_idx_reg];
        age     = now_reg - p_ent.seen;
        dc1     = {1'b0, p_ent.decay} + 5'd1;
        thr     = {21'd0, dc1} * {5'd0, ivl};
        is_exp  = p_valid && (age >= {11'd0, tmo});
        stop    = p_vld_reg && (cmd_reg == nte_pkg::CMD_TICK) && is_exp
                  && (ng_reg == NG_W'(MAX_EXPIRED_PER_TICK));
        do_decay = p_valid && !is_exp && (age >= {11'd0, ivl})
                   && (p_ent.decay < 4'(DECAY_LIMIT)) && (age >= {6'd0, thr});
        key     = (cmd_reg == nte_pkg::CMD_FIND) ? qid_reg : src_reg;
        hit     = p_valid && (p_ent.node == key);
        proc    = ctl.scan_step && p_vld_reg && !stop;
        rd_go   = ctl.scan_step && (rd_ptr_reg < PTR_W'(TABLE_ENTRIES));
    end

    always_comb
    begin
        stat.cmd       = cmd_reg;
        stat.drop      = (len_reg < 8'(BEACON_BYTES)) || (src_reg == own_id);
        stat.mode_zero = (mode_reg == nte_pkg::MODE_DEEP_SLEEP);
        stat.shrink    = nte_pkg::interval_of(nmode_reg) < ivl;
        stat.scan_end  = p_vld_reg && ((p_idx_reg == IDX_W'(TABLE_ENTRIES - 1)) || stop);
        stat.bcn_due   = (now_reg - lbt_reg) >= {11'd0, ivl};
        stat.any_down  = (ng_reg != '0);
        stat.last_down = (down_ptr_reg == (ng_reg - NG_W'(1)));
    end

    // Table write port: decay and restamp during the scan, beacon update after it.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = p_idx_reg;
        wr_data = p_ent;
        if (proc && (cmd_reg == nte_pkg::CMD_TICK) && do_decay)
        begin
            wr_en           = 1'b1;
            wr_data.history = {p_ent.history[6:0], 1'b0};
            wr_data.quality = nte_pkg::quality_of({p_ent.history[6:0], 1'b0});
            wr_data.decay   = p_ent.decay + 4'd1;
        end
        else if (proc && (cmd_reg == nte_pkg::CMD_MODE) && p_valid)
        begin
            wr_en        = 1'b1;
            wr_data.seen = now_reg;
        end
        else if (ctl.commit && (match_reg || free_reg))
        begin
            wr_en   = 1'b1;
            wr_addr = match_reg ? match_idx_reg : free_idx_reg;
            if (match_reg)
            begin
                wr_data.node    = match_ent_reg.node;
                wr_data.history = {match_ent_reg.history[6:0], 1'b1};
                wr_data.quality = nte_pkg::quality_of({match_ent_reg.history[6:0], 1'b1});
            end
            else
            begin
                wr_data.node    = src_reg;
                wr_data.history = nte_pkg::HISTORY_NEW;
                wr_data.quality = nte_pkg::QUALITY_NEW;
            end
            wr_data.rssi       = rssi_reg;
            wr_data.seen       = now_reg;
            wr_data.hop        = shop_reg;
            wr_data.power      = spow_reg;
            wr_data.capability = scap_reg;
            wr_data.decay      = 4'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_go)
        begin
            rd_data_reg <= mem[rd_ptr_reg[IDX_W-1:0]];
        end
    end

    // Payload registers with no reset.
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg   <= nte_pkg::cmd_code_t'(command);
            now_reg   <= now_ms;
            src_reg   <= source_id;
            len_reg   <= packet_length;
            shop_reg  <= source_hop;
            spow_reg  <= source_power;
            scap_reg  <= source_capability;
            rssi_reg  <= received_rssi;
            nmode_reg <= new_mode;
            qid_reg   <= query_id;
        end
        if (rd_go)
        begin
            p_idx_reg <= rd_ptr_reg[IDX_W-1:0];
        end
        if (proc && hit && !match_reg)
        begin
            match_idx_reg <= p_idx_reg;
            match_ent_reg <= p_ent;
        end
        if (proc && !p_valid && !free_reg)
        begin
            free_idx_reg <= p_idx_reg;
        end
        if (proc && (cmd_reg == nte_pkg::CMD_TICK) && is_exp)
        begin
            gone_reg[ng_reg[GI_W-1:0]] <= p_ent.node;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= nte_pkg::MODE_DEEP_SLEEP;
            pending_reg  <= 1'b1;
            bcnt_reg     <= 8'd0;
            vcount_reg   <= '0;
            lbt_reg      <= 32'd0;
            valid_reg    <= '0;
            rd_ptr_reg   <= '0;
            p_vld_reg    <= 1'b0;
            match_reg    <= 1'b0;
            free_reg     <= 1'b0;
            ng_reg       <= '0;
            down_ptr_reg <= '0;
        end
        else
        begin
            if (ctl.decode)
            begin
                rd_ptr_reg   <= '0;
                p_vld_reg    <= 1'b0;
                match_reg    <= 1'b0;
                free_reg     <= 1'b0;
                ng_reg       <= '0;
                down_ptr_reg <= '0;
                if (cmd_reg == nte_pkg::CMD_MODE)
                begin
                    mode_reg <= nmode_reg;
                    if ((mode_reg == nte_pkg::MODE_DEEP_SLEEP)
                        && (nmode_reg != nte_pkg::MODE_DEEP_SLEEP))
                    begin
                        pending_reg <= 1'b1;
                    end
                end
                if ((cmd_reg == nte_pkg::CMD_TICK)
                    && (mode_reg != nte_pkg::MODE_DEEP_SLEEP) && pending_reg)
                begin
                    lbt_reg     <= now_reg - {11'd0, ivl};
                    pending_reg <= 1'b0;
                end
            end
            if (ctl.scan_step)
            begin
                p_vld_reg <= rd_go;
                if (rd_go)
                begin
                    rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
                end
            end
            if (proc && hit)
            begin
                match_reg <= 1'b1;
            end
            if (proc && !p_valid)
            begin
                free_reg <= 1'b1;
            end
            if (proc && (cmd_reg == nte_pkg::CMD_TICK) && is_exp)
            begin
                ng_reg               <= ng_reg + NG_W'(1);
                valid_reg[p_idx_reg] <= 1'b0;
                vcount_reg           <= vcount_reg - CNT_W'(1);
            end
            if (ctl.commit && !match_reg && free_reg)
            begin
                valid_reg[free_idx_reg] <= 1'b1;
                vcount_reg              <= vcount_reg + CNT_W'(1);
            end
            if (ctl.emit_bcn)
            begin
                bcnt_reg <= bcnt_reg + 8'd1;
                lbt_reg  <= now_reg;
            end
            if (ctl.emit_down)
            begin
                down_ptr_reg <= down_ptr_reg + NG_W'(1);
            end
        end
    end

    assign vcount_ext = {6'd0, vcount_reg};

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_strobe <= 1'b0;
        end
        else
        begin
            result_strobe <= ctl.emit_find || ctl.emit_bcn || ctl.emit_down;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.emit_find || ctl.emit_bcn || ctl.emit_down)
        begin
            hop_count       <= 8'd0;
            tx_power        <= 8'sd0;
            capability      <= 8'd0;
            signal_strength <= 8'd0;
            link_quality    <= 7'd0;
            seen_time_ms    <= 32'd0;
            neighbor_total  <= 6'd0;
            beacon_sequence <= 8'd0;
            found           <= 1'b0;
            if (ctl.emit_find)
            begin
                item_kind <= nte_pkg::KIND_FIND;
                node_id   <= qid_reg;
                last_item <= 1'b1;
                if (match_reg)
                begin
                    hop_count       <= match_ent_reg.hop;
                    tx_power        <= $signed(match_ent_reg.power);
                    capability      <= match_ent_reg.capability;
                    signal_strength <= match_ent_reg.rssi;
                    link_quality    <= match_ent_reg.quality;
                    seen_time_ms    <= match_ent_reg.seen;
                    found           <= 1'b1;
                end
            end
            else if (ctl.emit_bcn)
            begin
                item_kind       <= nte_pkg::KIND_BEACON;
                node_id         <= own_id;
                hop_count       <= own_hop;
                tx_power        <= $signed(own_tx_power);
                capability      <= nte_pkg::BEACON_CAP;
                neighbor_total  <= vcount_ext[5:0];
                beacon_sequence <= bcnt_reg;
                last_item       <= (ng_reg == '0);
            end
            else
            begin
                item_kind <= nte_pkg::KIND_LINK_DOWN;
                node_id   <= gone_reg[down_ptr_reg[GI_W-1:0]];
                last_item <= stat.last_down;
            end
        end
    end

endmodule

@@ rtl/core/nte_ctrl.sv @@
// ---------------------------------------------------------------------------
// Neighbor table controller
// Sequences decode, table scan, update and result transfers per command.
// ---------------------------------------------------------------------------
module nte_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  nte_pkg::stat_t stat,
    output nte_pkg::ctl_t  ctl
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_FINISH,
        S_DOWN
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                ctl.decode = 1'b1;
                case (stat.cmd)
                    nte_pkg::CMD_BEACON: state_next = stat.drop ? S_IDLE : S_SCAN;
                    nte_pkg::CMD_TICK:   state_next = stat.mode_zero ? S_IDLE : S_SCAN;
                    nte_pkg::CMD_MODE:   state_next = stat.shrink ? S_SCAN : S_IDLE;
                    default:             state_next = S_SCAN;
                endcase
            end
            S_SCAN:
            begin
                ctl.scan_step = 1'b1;
                if (stat.scan_end)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                state_next = S_IDLE;
                case (stat.cmd)
                    nte_pkg::CMD_BEACON: ctl.commit = 1'b1;
                    nte_pkg::CMD_FIND:   ctl.emit_find = 1'b1;
                    nte_pkg::CMD_TICK:
                    begin
                        ctl.emit_bcn = stat.bcn_due;
                        if (stat.any_down)
                        begin
                            state_next = S_DOWN;
                        end
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_DOWN:
            begin
                ctl.emit_down = 1'b1;
                if (stat.last_down)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

@@ rtl/core/neighbor_table_aging_engine.sv @@
// ---------------------------------------------------------------------------
// Neighbor table aging engine
// Mesh neighbor table with beacon intake, aging ticks, mode changes and find.
// ---------------------------------------------------------------------------
// A command transfer is taken on a rising edge where start is high and busy
// is low; the command fields are sampled on that edge. Busy drops in the
// cycle that carries the final result of the command, so that result is on
// the ports while the next command can already be taken.
// Beacon and mode-change commands give no results. A tick gives an optional
// beacon followed by up to MAX_EXPIRED_PER_TICK link-down results; a find
// gives exactly one result. Each result is held on the result ports for one
// cycle with result_strobe high, and last_item marks the final one.
// The receiver cannot hold results off, so none are ever stalled.
// Commands that skip the table: a dropped beacon, a deep-sleep tick or a
// mode change that does not shorten the interval goes from decode straight
// back to idle. Anything else walks the table memory, one entry per cycle,
// through its read port while updates go through a separate write port,
// then finishes and sends any link-down results.
// Reset clears every valid bit at once, so the table is usable as soon as
// reset is released; the configuration registers return to their defaults.
// The APB port accepts register writes at any time; write it only while idle.
// ---------------------------------------------------------------------------
`include "neighbor_table_aging_engine_defines.svh"

module neighbor_table_aging_engine #(
    parameter int TABLE_ENTRIES        = 32,
    parameter int MAX_EXPIRED_PER_TICK = 4,
    parameter int DECAY_LIMIT          = 8,
    parameter int BEACON_BYTES         = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        command,
    input  logic [31:0]       now_ms,
    input  logic [15:0]       source_id,
    input  logic [7:0]        packet_length,
    input  logic [7:0]        source_hop,
    input  logic signed [7:0] source_power,
    input  logic [7:0]        source_capability,
    input  logic [7:0]        received_rssi,
    input  logic [1:0]        new_mode,
    input  logic [15:0]       query_id,
    output logic              result_strobe,
    output logic [1:0]        item_kind,
    output logic [15:0]       node_id,
    output logic [7:0]        hop_count,
    output logic signed [7:0] tx_power,
    output logic [7:0]        capability,
    output logic [7:0]        signal_strength,
    output logic [6:0]        link_quality,
    output logic [31:0]       seen_time_ms,
    output logic [5:0]        neighbor_total,
    output logic [7:0]        beacon_sequence,
    output logic              found,
    output logic              last_item
);

    // Configuration registers. The word index is the address divided by four.
    logic [15:0] own_id_reg;
    logic [7:0]  own_hop_reg;
    logic [7:0]  own_tx_power_reg;
    logic        cfg_write;

    nte_pkg::ctl_t  ctl;
    nte_pkg::stat_t stat;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_id_reg       <= 16'd0;
            own_hop_reg      <= nte_pkg::OWN_HOP_RESET;
            own_tx_power_reg <= 8'd0;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                nte_pkg::REG_OWN_ID:       own_id_reg       <= pwdata[15:0];
                nte_pkg::REG_OWN_HOP:      own_hop_reg      <= pwdata[7:0];
                nte_pkg::REG_OWN_TX_POWER: own_tx_power_reg <= pwdata[7:0];
                default:                   own_id_reg       <= own_id_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            nte_pkg::REG_OWN_ID:       prdata = {16'd0, own_id_reg};
            nte_pkg::REG_OWN_HOP:      prdata = {24'd0, own_hop_reg};
            nte_pkg::REG_OWN_TX_POWER: prdata = {24'd0, own_tx_power_reg};
            default:                   prdata = 32'd0;
        endcase
    end

    // The controller walks each command through decode, the table scan and
    // the result transfers; the datapath holds the table and does the work.
    nte_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .ctl   (ctl)
    );

    nte_datapath #(
        .TABLE_ENTRIES        (TABLE_ENTRIES),
        .MAX_EXPIRED_PER_TICK (MAX_EXPIRED_PER_TICK),
        .DECAY_LIMIT          (DECAY_LIMIT),
        .BEACON_BYTES         (BEACON_BYTES)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .ctl               (ctl),
        .stat              (stat),
        .own_id            (own_id_reg),
        .own_hop           (own_hop_reg),
        .own_tx_power      (own_tx_power_reg),
        .command           (command),
        .now_ms            (now_ms),
        .source_id         (source_id),
        .packet_length     (packet_length),
        .source_hop        (source_hop),
        .source_power      (source_power),
        .source_capability (source_capability),
        .received_rssi     (received_rssi),
        .new_mode          (new_mode),
        .query_id          (query_id),
        .result_strobe     (result_strobe),
        .item_kind         (item_kind),
        .node_id           (node_id),
        .hop_count         (hop_count),
        .tx_power          (tx_power),
        .capability        (capability),
        .signal_strength   (signal_strength),
        .link_quality      (link_quality),
        .seen_time_ms      (seen_time_ms),
        .neighbor_total    (neighbor_total),
        .beacon_sequence   (beacon_sequence),
        .found             (found),
        .last_item         (last_item)
    );

    // An accepted command always occupies the engine in the next cycle.
    `NTE_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    // The final result of a command is never followed directly by another.
    `NTE_ASSERT_NEXT(a_last_alone, result_strobe && last_item, !result_strobe)
    // Neither idle nor decode produces a result, so an accept is followed by a quiet cycle.
    `NTE_ASSERT_NEXT(a_decode_quiet, start && !busy, !result_strobe)

endmodule
